@@ design/bounded_insertable_array_unit_defines.svh @@
// Assertion macros shared by the bounded insertable array unit.
`ifndef BOUNDED_INSERTABLE_ARRAY_UNIT_DEFINES_SVH
`define BOUNDED_INSERTABLE_ARRAY_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on clk and skipped while reset is asserted.
`define BIAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on clk at every edge, reset included.
`define BIAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BIAU_ASSERT(lbl, prop, msg)
`define BIAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/biau_pkg.sv @@
// Types, constants and codes of the bounded insertable array unit.
package biau_pkg;

  localparam int DEPTH   = 32;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 6;
  localparam int CAP_W   = 6;
  localparam int OP_W    = 3;
  localparam int ST_W    = 2;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(20);

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT     = 3'd4,
    OP_GET        = 3'd5,
    OP_SET        = 3'd6
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_t;

  // Command broadcast to every cell of the row for one transfer.
  typedef struct packed {
    logic             up_en;    // cells in (lo, count] take their lower neighbor
    logic             down_en;  // cells below count-1 take their upper neighbor
    logic             ld_en;    // cell ld_idx takes value
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] ld_idx;
    logic [CNT_W-1:0] count;
    word_t            value;
  } cmd_t;

endpackage

@@ design/biau_cell.sv @@
// One storage cell of the array: hold, load, shift up or shift down.
module biau_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [biau_pkg::CNT_W-1:0] cell_idx,
  input  biau_pkg::cmd_t            cmd,
  input  biau_pkg::word_t           up_in,
  input  biau_pkg::word_t           down_in,
  output biau_pkg::word_t           q
);
  import biau_pkg::*;

  word_t            q_r;
  word_t            q_nxt;
  logic [CNT_W-1:0] idx_plus1;
  logic             do_ld;
  logic             do_up;
  logic             do_down;

  assign idx_plus1 = CNT_W'(cell_idx + 1'b1);
  assign do_ld     = cmd.ld_en && (cell_idx == cmd.ld_idx);
  assign do_up     = cmd.up_en && (cell_idx > cmd.lo) && (cell_idx <= cmd.count);
  assign do_down   = cmd.down_en && (idx_plus1 < cmd.count);

  // Select the next content of this cell.
  always_comb begin
    if (do_ld) begin
      q_nxt = cmd.value;
    end else if (do_up) begin
      q_nxt = up_in;
    end else if (do_down) begin
      q_nxt = down_in;
    end else begin
      q_nxt = q_r;
    end
  end

  // The store is cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

@@ design/biau_cell_row.sv @@
// Row of cells chained to their neighbors, with the read selector.
module biau_cell_row (
  input  logic                       clk,
  input  logic                       rst_n,
  input  biau_pkg::cmd_t             cmd,
  input  logic [biau_pkg::IDX_W-1:0] rd_idx,
  output biau_pkg::word_t            rd_data
);
  import biau_pkg::*;

  word_t cell_q [DEPTH];

  // Each cell sees the cell below it and the cell above it.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t up_in;
    word_t down_in;

    if (i == 0) begin : g_first
      assign up_in = '0;
    end else begin : g_mid_lo
      assign up_in = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign down_in = '0;
    end else begin : g_mid_hi
      assign down_in = cell_q[i+1];
    end

    biau_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (CNT_W'(i)),
      .cmd      (cmd),
      .up_in    (up_in),
      .down_in  (down_in),
      .q        (cell_q[i])
    );
  end

  // Read port for get.
  assign rd_data = cell_q[rd_idx];

endmodule

@@ design/bounded_insertable_array_unit.sv @@
// Top level of the bounded insertable array unit.
//
// Keeps an ordered list of signed 32-bit words in a row of 32 cells plus an
// entry count, bounded by the capacity register (cfg_we / cfg_wdata, reset
// value 20, effective capacity min(capacity, 32)).
// Requests arrive on in_valid / in_ready with in_op, in_position, in_value:
// push front, push back, pop front, pop back, insert, get and set.
// Every request gives exactly one result on out_valid / out_ready carrying
// out_read_value, out_count and out_status.
// A request is decoded in the cycle of its transfer: every cell takes its
// next content from itself, the value, or a neighbor, so the whole list
// shifts with the transfer. The result appears in the output register in
// the cycle after the transfer; unless stalled, a new request is taken
// every cycle. in_ready is high while the output register is empty or
// being emptied, so a stalled receiver holds one finished result and then
// blocks the input. Synchronous reset clears all cells, the count, out_valid
// and out_count and sets the capacity to 20. No clearing pass follows reset.
module bounded_insertable_array_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [biau_pkg::CAP_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [biau_pkg::OP_W-1:0]  in_op,
  input  logic [biau_pkg::POS_W-1:0] in_position,
  input  biau_pkg::word_t            in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output biau_pkg::word_t            out_read_value,
  output logic [biau_pkg::CNT_W-1:0] out_count,
  output logic [biau_pkg::ST_W-1:0]  out_status
);
  import biau_pkg::*;

  `include "bounded_insertable_array_unit_defines.svh"

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  word_t            out_read_value_r;
  logic [CNT_W-1:0] out_count_r;
  status_t          out_status_r;

  logic             in_accept;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  logic             pos_ok;
  op_t              op;
  cmd_t             cmd;
  status_t          status;
  word_t            rd_data;
  word_t            rd_value;

  assign in_accept = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign op        = op_t'(in_op);

  // Capacity compare in a common width.
  assign eff_cap = (CMP_W'(cap_r) < CMP_W'(DEPTH)) ? CMP_W'(cap_r) : CMP_W'(DEPTH);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = cnt_ext >= eff_cap;
  assign empty   = (count_r == '0);
  assign pos_ok  = pos_ext < eff_cap;

  // Request decode: the cell command, the new count and the status.
  always_comb begin
    cmd         = '0;
    cmd.count   = count_r;
    cmd.value   = in_value;
    count_nxt   = count_r;
    status      = ST_DONE;
    rd_value    = '0;
    unique case (op)
      OP_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.up_en  = 1'b1;
          cmd.ld_en  = 1'b1;
          count_nxt  = CNT_W'(count_r + 1'b1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ld_en  = 1'b1;
          cmd.ld_idx = count_r;
          count_nxt  = CNT_W'(count_r + 1'b1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          cmd.down_en = 1'b1;
          count_nxt   = CNT_W'(count_r - 1'b1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          // A position past the tail appends.
          cmd.lo     = (pos_ext > cnt_ext) ? count_r : CNT_W'(pos_ext);
          cmd.ld_idx = cmd.lo;
          cmd.up_en  = 1'b1;
          cmd.ld_en  = 1'b1;
          count_nxt  = CNT_W'(count_r + 1'b1);
        end
      end
      OP_GET: begin
        if (!pos_ok) begin
          status = ST_OUT_RANGE;
        end else begin
          rd_value = rd_data;
        end
      end
      OP_SET: begin
        if (!pos_ok) begin
          status = ST_OUT_RANGE;
        end else begin
          cmd.ld_en  = 1'b1;
          cmd.ld_idx = CNT_W'(pos_ext);
        end
      end
      default: begin
      end
    endcase
    // Nothing changes without a transfer.
    if (!in_accept) begin
      cmd.up_en   = 1'b0;
      cmd.down_en = 1'b0;
      cmd.ld_en   = 1'b0;
    end
  end

  biau_cell_row u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (IDX_W'(pos_ext)),
    .rd_data (rd_data)
  );

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // Entry count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r <= count_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; out_count mirrors the stored count, so it is cleared too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r <= '0;
    end else if (in_accept) begin
      out_count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_read_value_r <= rd_value;
      out_status_r     <= status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_status     = out_status_r;

  // Checks on the count and the result register.
  `BIAU_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "count exceeds depth")
  `BIAU_ASSERT(a_count_stable, !in_accept |=> $stable(count_r), "count moved without transfer")
  `BIAU_ASSERT(a_push_back_inc, in_accept && op == OP_PUSH_BACK && !full |=> out_count_r == CNT_W'($past(count_r) + 1'b1), "push back count wrong")
  `BIAU_ASSERT_ALWAYS(a_out_count_mirror, !rst_n || out_count_r == count_r, "result count differs from stored count")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the bounded insertable array unit.
module testbench;
  import biau_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    word_t            read_value;
    logic [CNT_W-1:0] count;
    status_t          status;
  } reply_t;

  // Tracks the list contents and the replies that the block owes.
  class list_scoreboard;
    word_t            cells[DEPTH];
    int unsigned      entry_count;
    logic [CAP_W-1:0] capacity;
    reply_t           expected_replies[$];
    int               mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      entry_count = 0;
      capacity = CAP_RESET;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    endfunction

    // Applies one accepted request to the list and queues its reply.
    function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] position,
                               word_t value);
      reply_t      reply;
      int unsigned limit;
      int          slot;
      bit          full;
      limit = (capacity < DEPTH) ? capacity : DEPTH;
      full = (entry_count >= limit);
      slot = position;
      reply.read_value = '0;
      reply.status = ST_DONE;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
          if (full) begin
            reply.status = ST_FULL;
          end else begin
            if (op == OP_PUSH_FRONT) slot = 0;
            else if (op == OP_PUSH_BACK || slot > entry_count) slot = entry_count;
            // Entries from the slot upward move up one place.
            for (int i = entry_count; i > slot; i--) begin
              if (i < DEPTH) cells[i] = cells[i-1];
            end
            if (slot < DEPTH) cells[slot] = value;
            entry_count++;
          end
        end
        OP_POP_FRONT: begin
          if (entry_count == 0) begin
            reply.status = ST_EMPTY;
          end else begin
            for (int i = 0; i + 1 < entry_count && i + 1 < DEPTH; i++) cells[i] = cells[i+1];
            entry_count--;
          end
        end
        OP_POP_BACK: begin
          if (entry_count == 0) reply.status = ST_EMPTY;
          else entry_count--;
        end
        OP_GET: begin
          if (position >= limit) reply.status = ST_OUT_RANGE;
          else reply.read_value = cells[position];
        end
        OP_SET: begin
          if (position >= limit) reply.status = ST_OUT_RANGE;
          else cells[position] = value;
        end
        default: begin
        end
      endcase
      reply.count = CNT_W'(entry_count);
      expected_replies.push_back(reply);
    endfunction

    // Compares one reply transfer with the oldest outstanding one.
    function void check_reply(word_t read_value, logic [CNT_W-1:0] count,
                              logic [ST_W-1:0] status);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply: value %0d count %0d status %0d",
                         read_value, count, status));
        return;
      end
      want = expected_replies.pop_front();
      if (read_value !== want.read_value || count !== want.count || status !== want.status)
        report($sformatf(
          "expected value %0d count %0d status %s, got value %0d count %0d status %0d",
          want.read_value, want.count, want.status.name(),
          read_value, count, status));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_op;
  logic [POS_W-1:0] in_position;
  word_t            in_value;
  logic             out_valid;
  logic             out_ready;
  word_t            out_read_value;
  logic [CNT_W-1:0] out_count;
  logic [ST_W-1:0]  out_status;

  bit  send_idle;
  bit  take_idle;
  bit  hold_phase;
  bit  hold_done;
  int  quiet_cycles = 0;
  list_scoreboard board;

  bounded_insertable_array_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_status     (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every reply transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_reply(out_read_value, out_count, out_status);
  end

  // The run ends if no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** bounded_insertable_array_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_phase && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready = !take_idle || ($urandom_range(99) >= 15);
    end
  end

  // Offers one request and returns at the falling edge after its transfer.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] position,
                              input word_t value);
    while (send_idle && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_op = op;
    in_position = position;
    in_value = value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(op, position, value);
    @(negedge clk);
  endtask

  // Stops offering and waits until every reply has come back.
  task automatic settle();
    in_valid = 1'b0;
    while (board.expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] limit);
    settle();
    cfg_wdata = limit;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    board.capacity = limit;
  endtask

  // Random requests; grow_pct steers how often the list grows.
  task automatic run_random(input int items, input int grow_pct);
    int               pick;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] position;
    word_t            value;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        op = OP_UNUSED;
      end else if (pick < 2 + grow_pct) begin
        case ($urandom_range(2))
          0: op = OP_PUSH_FRONT;
          1: op = OP_PUSH_BACK;
          default: op = OP_INSERT;
        endcase
      end else if (pick < 72) begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end else begin
        op = $urandom_range(1) ? OP_GET : OP_SET;
      end
      pick = $urandom_range(99);
      if (pick < 50) position = POS_W'($urandom_range(board.entry_count, 0));
      else if (pick < 85) position = POS_W'($urandom_range(32, 0));
      else position = POS_W'($urandom_range(63, 0));
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(3))
          0: value = 32'h8000_0000;
          1: value = 32'h7fff_ffff;
          2: value = '0;
          default: value = '1;
        endcase
      end else begin
        value = $urandom;
      end
      send_request(op, position, value);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_op = OP_PUSH_FRONT;
    in_position = '0;
    in_value = '0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    hold_phase = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Empty list, reset capacity: cleared store and rejected pops.
    send_request(OP_GET, 0, 0);
    send_request(OP_POP_FRONT, 0, 0);
    send_request(OP_POP_BACK, 0, 0);
    // Extremes at both ends, insert in the middle and past the tail.
    send_request(OP_PUSH_BACK, 0, 32'h7fff_ffff);
    send_request(OP_PUSH_FRONT, 0, 32'h8000_0000);
    send_request(OP_INSERT, 1, '1);
    send_request(OP_INSERT, 63, 0);
    // Get and set above the count but below capacity, then out of range.
    send_request(OP_GET, 19, 0);
    send_request(OP_GET, 20, 0);
    send_request(OP_SET, 19, 32'h1234_5678);
    send_request(OP_GET, 19, 0);
    send_request(OP_SET, 63, '1);
    send_request(OP_GET, 63, 0);
    send_request(OP_UNUSED, 63, '1);
    send_request(OP_GET, 1, 0);
    // Pops do not clear the cells they free.
    send_request(OP_POP_FRONT, 0, 0);
    send_request(OP_POP_BACK, 0, 0);
    send_request(OP_GET, 0, 0);
    send_request(OP_GET, 3, 0);

    // Capacity lowered below the count: push front and insert are rejected.
    write_capacity(1);
    send_request(OP_PUSH_FRONT, 0, 5);
    send_request(OP_INSERT, 0, 6);
    send_request(OP_GET, 0, 0);
    send_request(OP_GET, 1, 0);

    // Zero capacity: nothing fits and no position is in range.
    write_capacity(0);
    send_request(OP_PUSH_BACK, 0, 7);
    send_request(OP_SET, 0, 8);
    send_request(OP_POP_BACK, 0, 0);

    // Full depth: fill up, then drain.
    write_capacity(32);
    run_random(200, 55);
    run_random(150, 25);

    write_capacity(1);
    run_random(100, 40);

    // Register above the depth, with a long stretch of no idling.
    write_capacity(63);
    send_idle = 1'b0;
    take_idle = 1'b0;
    run_random(200, 45);

    // Receiver holds off while the sender keeps offering.
    hold_phase = 1'b1;
    run_random(60, 45);
    hold_phase = 1'b0;
    send_idle = 1'b1;
    take_idle = 1'b1;

    write_capacity(CAP_W'($urandom_range(32, 2)));
    run_random(200, $urandom_range(60, 20));

    write_capacity(20);
    run_random(190, 35);

    settle();
    if (board.mismatches == 0 && board.expected_replies.size() == 0)
      $display("** bounded_insertable_array_unit: PASSED **");
    else
      $display("** bounded_insertable_array_unit: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/biau_pkg.sv
design/biau_cell.sv
design/biau_cell_row.sv
design/bounded_insertable_array_unit.sv
bench/testbench.sv
